### hw/rtl/ttc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and constants of the transposition table cluster block.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int INDEX_BITS    = 10;
    localparam int WAYS          = 4;
    localparam int WAY_BITS      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int STALE_PENALTY = 1000;
    localparam logic [14:0] MATE_BOUND_RST = 15'd31000;

    // func codes
    localparam logic [1:0] FUNC_STORE = 2'd0;
    localparam logic [1:0] FUNC_PROBE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // bound flag codes
    localparam logic [1:0] FLAG_EXACT = 2'd0;
    localparam logic [1:0] FLAG_UPPER = 2'd1;
    localparam logic [1:0] FLAG_LOWER = 2'd2;

    // config register indexes
    localparam logic CFG_GEN       = 1'b0;
    localparam logic CFG_MATE_BND  = 1'b1;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [6:0]         depth;
        logic [1:0]         flag;
        logic [7:0]         age;
        logic [15:0]        move;
        logic [3:0]         piece;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [7:0]         ply;
        logic signed [7:0]  depth;
        logic [1:0]         flag;
        logic               move_valid;
        logic [15:0]        move_data;
        logic [3:0]         move_piece;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } t_req;

    typedef struct packed {
        logic               key_found;
        logic               score_usable;
        logic signed [15:0] score;
        logic               move_present;
        logic [15:0]        move_data;
        logic [3:0]         move_piece;
    } t_res;

endpackage
`default_nettype wire

### hw/rtl/ttc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttc_ram #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ttc_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttc_update
// Way compare, replacement choice, entry update and probe result.
// ----------------------------------------------------------------------------
module ttc_update import ttc_pkg::*; (
    input  wire logic [1:0]  i_func,
    input  wire t_req        i_req,
    input  wire t_row        i_row,
    input  wire logic [7:0]  i_gen,
    input  wire logic [14:0] i_mate_bound,
    output t_row             o_row,
    output t_res             o_res
);

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) r = 16'sh7fff;
        else if (v < -18'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    // away: 1 moves mate scores away from zero, 0 toward zero
    function automatic logic signed [15:0] mate_adj(input logic signed [15:0] s,
                                                    input logic [7:0] ply,
                                                    input logic [14:0] mb,
                                                    input logic away);
        logic [16:0]        mag;
        logic signed [17:0] se;
        logic signed [17:0] pe;
        logic               pos;
        logic signed [15:0] r;
        mag = s[15] ? (17'd0 - {s[15], s}) : {1'b0, s};
        se  = {{2{s[15]}}, s};
        pe  = $signed({10'd0, ply});
        pos = !s[15] && (s != 16'sd0);
        if (mag > {2'b00, mb}) begin
            r = sat16((pos == away) ? (se + pe) : (se - pe));
        end else begin
            r = s;
        end
        return r;
    endfunction

    logic [WAY_BITS-1:0] pick;
    logic                done;
    logic                have;
    logic signed [10:0]  bad;
    logic signed [10:0]  worst;
    logic [6:0]          depth_c;
    t_entry              sel;
    t_entry              upd;
    logic signed [15:0]  wscore;
    logic signed [15:0]  pscore;
    logic                found;
    t_entry              hit;
    logic                ok;

    assign depth_c = i_req.depth[7] ? 7'd0 : i_req.depth[6:0];
    assign wscore  = mate_adj(i_req.score, i_req.ply, i_mate_bound, 1'b1);

    // store: first matching/empty way, else worst by age and depth
    always_comb begin
        pick  = '0;
        done  = 1'b0;
        have  = 1'b0;
        worst = '0;
        bad   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!done) begin
                if (i_row[w].key == i_req.key || i_row[w].key == 64'd0) begin
                    pick = WAY_BITS'(w);
                    done = 1'b1;
                end else begin
                    bad = (i_row[w].age != i_gen) ?
                          (11'(STALE_PENALTY) - $signed({4'd0, i_row[w].depth})) :
                          (11'sd0 - $signed({4'd0, i_row[w].depth}));
                    if (!have || bad > worst) begin
                        worst = bad;
                        pick  = WAY_BITS'(w);
                        have  = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        sel = i_row[pick];
        upd = sel;
        if (sel.key == i_req.key) begin
            upd.age = i_gen;
            if (i_req.move_valid) begin
                upd.move  = i_req.move_data;
                upd.piece = i_req.move_piece;
            end
            if (depth_c >= sel.depth) begin
                upd.score = wscore;
                upd.depth = depth_c;
                upd.flag  = i_req.flag;
            end
        end else begin
            upd.key   = i_req.key;
            upd.score = wscore;
            upd.depth = depth_c;
            upd.flag  = i_req.flag;
            upd.age   = i_gen;
            upd.move  = i_req.move_valid ? i_req.move_data : 16'd0;
            upd.piece = i_req.move_valid ? i_req.move_piece : 4'd0;
        end
        o_row       = i_row;
        o_row[pick] = upd;
    end

    // probe: first way with matching key
    always_comb begin
        found = 1'b0;
        hit   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && i_row[w].key == i_req.key) begin
                found = 1'b1;
                hit   = i_row[w];
            end
        end
    end

    assign pscore = mate_adj(hit.score, i_req.ply, i_mate_bound, 1'b0);

    always_comb begin
        ok = 1'b0;
        if ($signed({1'b0, hit.depth}) >= i_req.depth) begin
            unique case (hit.flag)
                FLAG_EXACT: ok = 1'b1;
                FLAG_UPPER: ok = (pscore <= i_req.alpha);
                FLAG_LOWER: ok = (pscore >= i_req.beta);
                default:    ok = 1'b0;
            endcase
        end
        o_res = '0;
        if (i_func == FUNC_PROBE && found) begin
            o_res.key_found = 1'b1;
            if (hit.move != 16'd0) begin
                o_res.move_present = 1'b1;
                o_res.move_data    = hit.move;
                o_res.move_piece   = hit.piece;
            end
            if (ok) begin
                o_res.score_usable = 1'b1;
                o_res.score        = pscore;
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/transposition_table_cluster_top.sv
`default_nettype none
// Store and probe: the cluster row read is registered in the single table RAM;
//   a store writes the updated row back as the result is registered, once the
//   result register is free. A new input beat is taken only after that result.
// Clear: one cluster row zeroed per cycle, then a result beat of zeros.
// Reset: synchronous, active low; a clearing pass follows reset, during which
//   no input beat is taken (config writes still are).
// ----------------------------------------------------------------------------
// transposition_table_cluster_top
// Bucketed hash table with depth/age replacement, stream in, stream out.
// ----------------------------------------------------------------------------
module transposition_table_cluster_top import ttc_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input beat
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // key, score_in, ply, depth_in, bound_flag, move_valid, move_data_in,
    // move_piece_in, alpha, beta (low bit up), one pad bit
    input  wire logic [151:0] i_s_tdata,
    // func
    input  wire logic [1:0]   i_s_tuser,
    // result beat
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // key_found, score_usable, score_out, move_present, move_data_out,
    // move_piece_out (low bit up), one pad bit
    output logic [39:0]       o_m_tdata,
    // config write port
    input  wire logic         i_cfg_wr_en,
    input  wire logic         i_cfg_addr,
    input  wire logic [14:0]  i_cfg_wdata
);

    localparam logic [1:0] S_CLR  = 2'd0;  // zeroing sweep
    localparam logic [1:0] S_IDLE = 2'd1;  // take a beat
    localparam logic [1:0] S_CMP  = 2'd2;  // row read back, update
    localparam logic [1:0] S_DONE = 2'd3;  // clear result

    logic [1:0]            r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_addr;
    logic                  r_clr_op;
    logic [7:0]            r_gen;
    logic [14:0]           r_mb;
    logic [1:0]            r_func;
    t_req                  r_req;
    logic                  r_out_valid;
    t_res                  r_out;

    logic                  accept;
    logic                  slot_free;
    t_req                  in_req;
    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic [ROW_W-1:0]      ram_rdata;
    t_row                  upd_row;
    t_res                  upd_res;

    assign in_req.key        = i_s_tdata[63:0];
    assign in_req.score      = i_s_tdata[79:64];
    assign in_req.ply        = i_s_tdata[87:80];
    assign in_req.depth      = i_s_tdata[95:88];
    assign in_req.flag       = i_s_tdata[97:96];
    assign in_req.move_valid = i_s_tdata[98];
    assign in_req.move_data  = i_s_tdata[114:99];
    assign in_req.move_piece = i_s_tdata[118:115];
    assign in_req.alpha      = i_s_tdata[134:119];
    assign in_req.beta       = i_s_tdata[150:135];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    // result register free now or emptied this edge
    assign slot_free  = !r_out_valid || i_m_tready;

    // one row of WAYS entries per cluster
    ttc_ram #(
        .AW (INDEX_BITS),
        .DW (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (in_req.key[INDEX_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    ttc_update u_update (
        .i_func       (r_func),
        .i_req        (r_req),
        .i_row        (t_row'(ram_rdata)),
        .i_gen        (r_gen),
        .i_mate_bound (r_mb),
        .o_row        (upd_row),
        .o_res        (upd_res)
    );

    // write port: sweep zeros, or write back the updated row on a store
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_req.key[INDEX_BITS-1:0];
        ram_wdata = ROW_W'(upd_row);
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == S_CMP && slot_free && r_func == FUNC_STORE) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (&r_clr_addr) begin
                    n_state = r_clr_op ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_s_tuser == FUNC_CLEAR) ? S_CLR : S_CMP;
                end
            end
            S_CMP: begin
                if (slot_free) n_state = S_IDLE;
            end
            S_DONE: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_gen       <= 8'd0;
            r_mb        <= MATE_BOUND_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_GEN:      r_gen <= i_cfg_wdata[7:0];
                    CFG_MATE_BND: r_mb  <= i_cfg_wdata;
                    default:      ;
                endcase
            end
            if (accept && i_s_tuser == FUNC_CLEAR) begin
                r_gen      <= 8'd0;
                r_clr_addr <= '0;
                r_clr_op   <= 1'b1;
            end
            if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;
            if ((r_state == S_CMP || r_state == S_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= in_req;
            r_func <= i_s_tuser;
        end
        if (r_state == S_CMP && slot_free) r_out <= upd_res;
        if (r_state == S_DONE && slot_free) r_out <= '0;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.move_piece, r_out.move_data, r_out.move_present,
                         r_out.score, r_out.score_usable, r_out.key_found};

`ifndef SYNTHESIS
    a_cmp_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_CMP))
        else $error("update stage entered without a row read");

    a_cmp_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && slot_free) |=> (r_state == S_IDLE && r_out_valid))
        else $error("update did not retire into result register");

    a_clear_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tuser == FUNC_CLEAR) |=>
        (r_state == S_CLR && r_clr_addr == '0 && r_gen == 8'd0))
        else $error("clear op did not start sweep at row zero");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !ram_we)
        else $error("table write outside sweep or update");
`endif

endmodule
`default_nettype wire
